>>> sv/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg: shared types and constants of the button debouncer
// Register indexes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdh_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned NowWidth         = 32;
  localparam int unsigned DurWidth         = 16;
  localparam int unsigned CfgIdxWidth      = 8;
  localparam int unsigned CfgDataWidth     = 16;

  localparam logic [DurWidth-1:0] DebounceTimeReset = 16'd50;
  localparam logic [DurWidth-1:0] HoldTimeReset     = 16'd1000;
  localparam logic                PullupReset       = 1'b1;
  localparam logic                InvertedReset     = 1'b0;
  localparam logic                IdleLevelReset    = PullupReset ^ InvertedReset;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDebounceTime   = 8'd0,
    CfgHoldTime       = 8'd1,
    CfgPullupMode     = 8'd2,
    CfgPolarityInvert = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DurWidth-1:0] debounce_time;
    logic [DurWidth-1:0] hold_time;
    logic                pullup_mode;
    logic                polarity_invert;
  } cfg_t;

  typedef struct packed {
    logic pushed_event;
    logic released_event;
    logic held_event;
    logic any_change;
    logic is_pressed;
  } result_t;

endpackage

`default_nettype wire

>>> sv/bdh_if.sv
// ----------------------------------------------------------------------------
// bdh_if: channel interfaces of the button debouncer
// Pin sample channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bdh_in_if;
  logic                          valid;
  logic                          ready;
  logic                          pin_level;
  logic [bdh_pkg::NowWidth-1:0]  now_time;

  modport source (output valid, output pin_level, output now_time, input ready);
  modport sink (input valid, input pin_level, input now_time, output ready);
endinterface

interface bdh_out_if;
  logic valid;
  logic ready;
  logic pushed_event;
  logic released_event;
  logic held_event;
  logic any_change;
  logic is_pressed;

  modport source (output valid, output pushed_event, output released_event,
                  output held_event, output any_change, output is_pressed, input ready);
  modport sink (input valid, input pushed_event, input released_event,
                input held_event, input any_change, input is_pressed, output ready);
endinterface

interface bdh_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bdh_pkg::CfgIdxWidth-1:0]   index;
  logic [bdh_pkg::CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/bdh_engine.sv
// ----------------------------------------------------------------------------
// bdh_engine: debounce and hold state update
// Holds the debounce and hold timers and the debounced level, and updates
// them for one pin sample whenever the enable is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdh_engine #(
  parameter int unsigned TimeWidth = bdh_pkg::TimeWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          level_i,
  input  wire logic [bdh_pkg::NowWidth-1:0]  now_i,
  input  wire bdh_pkg::cfg_t                 cfg_i,
  output bdh_pkg::result_t                   res_o
);

  localparam int unsigned CmpWidth =
    (TimeWidth > bdh_pkg::DurWidth) ? TimeWidth : bdh_pkg::DurWidth;

  logic                         cand_q, cand_d;
  logic                         stable_q, stable_d;
  logic                         deb_run_q, deb_run_d;
  logic [TimeWidth-1:0]         deb_start_q, deb_start_d;
  logic [bdh_pkg::DurWidth-1:0] deb_len_q, deb_len_d;
  logic                         hold_run_q, hold_run_d;
  logic [TimeWidth-1:0]         hold_start_q, hold_start_d;
  logic [bdh_pkg::DurWidth-1:0] hold_len_q, hold_len_d;

  logic [TimeWidth-1:0] now_t;
  logic [TimeWidth-1:0] deb_diff;
  logic [TimeWidth-1:0] hold_diff;
  logic                 deb_expired;
  logic                 hold_expired;
  logic                 polarity;
  logic                 pressed_new;
  logic                 pushed;
  logic                 released;
  logic                 held;

  assign now_t    = TimeWidth'(now_i);
  assign polarity = cfg_i.pullup_mode ^ cfg_i.polarity_invert;
  assign deb_diff = now_t - deb_start_q;
  assign deb_expired = deb_run_q &&
    (CmpWidth'(deb_diff) >= CmpWidth'(deb_len_q));

  always_comb begin
    cand_d       = cand_q;
    stable_d     = stable_q;
    deb_run_d    = deb_run_q;
    deb_start_d  = deb_start_q;
    deb_len_d    = deb_len_q;
    hold_run_d   = hold_run_q;
    hold_start_d = hold_start_q;
    hold_len_d   = hold_len_q;
    pushed       = 1'b0;
    released     = 1'b0;
    held         = 1'b0;

    if ((stable_q != level_i) && !deb_run_q) begin
      cand_d      = level_i;
      deb_run_d   = 1'b1;
      deb_start_d = now_t;
      deb_len_d   = cfg_i.debounce_time;
    end else if (deb_expired) begin
      deb_run_d = 1'b0;
      if (cand_q == level_i) begin
        stable_d = level_i;
        if (level_i ^ polarity) begin
          hold_run_d   = 1'b1;
          hold_start_d = now_t;
          hold_len_d   = cfg_i.hold_time;
          pushed       = 1'b1;
        end else begin
          hold_run_d = 1'b0;
          released   = 1'b1;
        end
      end
    end

    // The hold check sees the timer as left by this sample's debounce update.
    pressed_new  = stable_d ^ polarity;
    hold_diff    = now_t - hold_start_d;
    hold_expired = hold_run_d &&
      (CmpWidth'(hold_diff) >= CmpWidth'(hold_len_d));
    if (pressed_new && hold_expired) begin
      hold_run_d = 1'b0;
      held       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q       <= bdh_pkg::IdleLevelReset;
      stable_q     <= bdh_pkg::IdleLevelReset;
      deb_run_q    <= 1'b0;
      deb_start_q  <= '0;
      deb_len_q    <= '0;
      hold_run_q   <= 1'b0;
      hold_start_q <= '0;
      hold_len_q   <= '0;
    end else if (en_i) begin
      cand_q       <= cand_d;
      stable_q     <= stable_d;
      deb_run_q    <= deb_run_d;
      deb_start_q  <= deb_start_d;
      deb_len_q    <= deb_len_d;
      hold_run_q   <= hold_run_d;
      hold_start_q <= hold_start_d;
      hold_len_q   <= hold_len_d;
    end
  end

  always_comb begin
    res_o.pushed_event   = pushed;
    res_o.released_event = released;
    res_o.held_event     = held;
    res_o.any_change     = pushed | released | held;
    res_o.is_pressed     = pressed_new;
  end

endmodule

`default_nettype wire

>>> sv/button_debounce_hold_detector_core.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_detector_core: button debouncer with long-press events
// A sample goes from the input register through the engine into the result
// register and waits while that is full and unread. Throughput: one sample per
// cycle while out_o.ready is high; the state update is one pass of compares.
// Reset: timers stop, the debounced level goes idle, config registers reload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_hold_detector_core #(
  parameter int unsigned TIME_WIDTH = bdh_pkg::TimeWidthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bdh_in_if.sink     in_i,
  bdh_out_if.source  out_o,
  bdh_cfg_if.sink    cfg_i
);

  bdh_pkg::cfg_t                 cfg_q, cfg_d;
  logic                          in_vld_q;
  logic                          in_level_q;
  logic [bdh_pkg::NowWidth-1:0]  in_now_q;
  logic                          out_vld_q;
  bdh_pkg::result_t              out_res_q;
  bdh_pkg::result_t              eng_res;
  logic                          advance;
  logic                          in_take;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (bdh_pkg::cfg_idx_e'(cfg_i.index))
        bdh_pkg::CfgDebounceTime:   cfg_d.debounce_time   = cfg_i.data;
        bdh_pkg::CfgHoldTime:       cfg_d.hold_time       = cfg_i.data;
        bdh_pkg::CfgPullupMode:     cfg_d.pullup_mode     = cfg_i.data[0];
        bdh_pkg::CfgPolarityInvert: cfg_d.polarity_invert = cfg_i.data[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= bdh_pkg::DebounceTimeReset;
      cfg_q.hold_time       <= bdh_pkg::HoldTimeReset;
      cfg_q.pullup_mode     <= bdh_pkg::PullupReset;
      cfg_q.polarity_invert <= bdh_pkg::InvertedReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register feeds the engine; the result register decouples the sink.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_level_q <= in_i.pin_level;
      in_now_q   <= in_i.now_time;
    end
    if (advance) begin
      out_res_q <= eng_res;
    end
  end

  bdh_engine #(
    .TimeWidth (TIME_WIDTH)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .level_i (in_level_q),
    .now_i   (in_now_q),
    .cfg_i   (cfg_q),
    .res_o   (eng_res)
  );

  assign out_o.valid          = out_vld_q;
  assign out_o.pushed_event   = out_res_q.pushed_event;
  assign out_o.released_event = out_res_q.released_event;
  assign out_o.held_event     = out_res_q.held_event;
  assign out_o.any_change     = out_res_q.any_change;
  assign out_o.is_pressed     = out_res_q.is_pressed;

`ifndef SYNTHESIS
  a_push_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_res_q.pushed_event && out_res_q.released_event))
    else $error("push and release reported together");

  a_any_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_res_q.any_change == (out_res_q.pushed_event ||
      out_res_q.released_event || out_res_q.held_event)))
    else $error("any_change does not match the event flags");

  a_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_res_q.pushed_event || out_res_q.held_event)) |->
      out_res_q.is_pressed)
    else $error("push or hold reported while not pressed");

  a_input_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_now_q)))
    else $error("pending sample lost before processing");
`endif

endmodule

`default_nettype wire
